[sv/rrdes_pkg.sv]
// Package of DES tables, round count and helper functions for the reduced-round cipher.
`default_nettype none
package rrdes_pkg;

   localparam int NUM_ROUNDS = 4;

   localparam logic CSR_CIPHER_KEY   = 1'b0;
   localparam logic CSR_DECRYPT_MODE = 1'b1;

   localparam logic [7:0] IP_TAB [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam logic [7:0] FP_TAB [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam logic [7:0] E_TAB [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam logic [7:0] P_TAB [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam logic [7:0] PC1_TAB [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
   localparam logic [7:0] PC2_TAB [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   localparam logic [7:0] ROT_TAB [16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
   localparam logic [3:0] S_TAB [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] ip_perm(input logic [63:0] v);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(IP_TAB[i])];
      return o;
   endfunction

   function automatic logic [63:0] fp_perm(input logic [63:0] v);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(FP_TAB[i])];
      return o;
   endfunction

   function automatic logic [55:0] pc1_perm(input logic [63:0] v);
      logic [55:0] o;
      for (int i = 0; i < 56; i++) o[55-i] = v[64-int'(PC1_TAB[i])];
      return o;
   endfunction

   function automatic logic [27:0] rot28(input logic [27:0] v, input int s);
      logic [27:0] o;
      for (int i = 0; i < 28; i++) o[(i + (s % 28)) % 28] = v[i];
      return o;
   endfunction

   // Subkey of a round: cumulative rotation of C and D, then PC-2.
   function automatic logic [47:0] subkey(input logic [55:0] cd, input int r);
      logic [55:0] t;
      logic [47:0] o;
      t = {rot28(cd[55:28], int'(ROT_TAB[r % 16])), rot28(cd[27:0], int'(ROT_TAB[r % 16]))};
      for (int i = 0; i < 48; i++) o[47-i] = t[56-int'(PC2_TAB[i])];
      return o;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] o;
      logic [5:0]  g;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(E_TAB[i])];
      x = x ^ k;
      for (int j = 0; j < 8; j++) begin
         g = x[47-6*j -: 6];
         s[31-4*j -: 4] = S_TAB[j][{g[5], g[0], g[4:1]}];
      end
      for (int i = 0; i < 32; i++) o[31-i] = s[32-int'(P_TAB[i])];
      return o;
   endfunction

endpackage
`default_nettype wire

[sv/reduced_round_des_cipher_unit.sv]
// Top level of the reduced-round DES cipher: key schedule registers and round pipeline.
// Throughput: one block per cycle; each round is one register stage, with IP and
// IP inverse in stages of their own. A stalled response freezes the whole pipeline.
// Reset (synchronous, active high) clears all valid bits, the key to zero and the
// mode to encrypt; the subkey registers are reloaded with the all-zero key subkeys.
`default_nettype none
module reduced_round_des_cipher_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // block_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // block_out
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int NR = rrdes_pkg::NUM_ROUNDS;
   localparam int NS = NR + 2;

   // Subkeys are stored already in the order the rounds use them.
   logic [47:0] key_ff [NR];
   logic [47:0] key_in [NR];
   logic [47:0] enc_key [NR];
   logic [55:0] cd;
   logic        dec_ff;
   logic [63:0] cipher_key_ff;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // The schedule is registered in the cycle after any key or mode write.
   assign cd = rrdes_pkg::pc1_perm(cipher_key_ff);
   always_comb begin
      for (int r = 0; r < NR; r++) enc_key[r] = rrdes_pkg::subkey(cd, r);
      for (int r = 0; r < NR; r++) key_in[r] = dec_ff ? enc_key[NR-1-r] : enc_key[r];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff <= '0;
         dec_ff        <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == rrdes_pkg::CSR_CIPHER_KEY) cipher_key_ff <= csr_data;
         if (csr_index == rrdes_pkg::CSR_DECRYPT_MODE) dec_ff <= csr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NR; r++) key_ff[r] <= key_in[r];
   end

   // Stage 0 holds IP output, stages 1..NR hold round outputs, stage NR+1 the result.
   logic [NS-1:0] vld_ff;
   logic [63:0]   dat_ff [NS];
   logic          adv;

   assign adv        = rsp_tready | ~vld_ff[NS-1];
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = dat_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dat_ff[0] <= rrdes_pkg::ip_perm(req_tdata);
         for (int r = 0; r < NR; r++) begin
            dat_ff[r+1] <= {dat_ff[r][31:0],
               dat_ff[r][63:32] ^ rrdes_pkg::feistel(dat_ff[r][31:0], key_ff[r])};
         end
         dat_ff[NS-1] <= rrdes_pkg::fp_perm({dat_ff[NR][31:0], dat_ff[NR][63:32]});
      end
   end

endmodule
`default_nettype wire

[verif/des_cipher_checker.sv]
// Checker for the reduced-round DES unit: tracks key and mode, predicts each block, compares.
module des_cipher_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_data,
   output int               error_count,
   output int               pending_blocks
);

   logic [47:0] key_sched [rrdes_pkg::NUM_ROUNDS];
   logic        decrypting;
   logic [63:0] expected_blocks [$];

   function automatic logic [63:0] bit_select(input logic [63:0] v, input int w,
                                              input logic [7:0] tab [], input int n);
      logic [63:0] o;
      o = '0;
      for (int i = 0; i < n; i++) o = {o[62:0], v[w - int'(tab[i])]};
      return o;
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] v, input int s);
      logic [55:0] d;
      d = {v, v} << (s % 28);
      return d[55:28];
   endfunction

   task automatic load_key(input logic [63:0] k);
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      int s;
      cd = 56'(bit_select(k, 64, rrdes_pkg::PC1_TAB, 56));
      for (int r = 0; r < rrdes_pkg::NUM_ROUNDS; r++) begin
         s = int'(rrdes_pkg::ROT_TAB[r % 16]);
         c = rotl28(cd[55:28], s);
         d = rotl28(cd[27:0], s);
         key_sched[r] = 48'(bit_select({8'h0, c, d}, 56, rrdes_pkg::PC2_TAB, 48));
      end
   endtask

   function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      logic [5:0]  g;
      x = 48'(bit_select({32'h0, r}, 32, rrdes_pkg::E_TAB, 48)) ^ k;
      for (int j = 0; j < 8; j++) begin
         g = x[47 - 6*j -: 6];
         s[31 - 4*j -: 4] = rrdes_pkg::S_TAB[j][{g[5], g[0], g[4:1]}];
      end
      return 32'(bit_select({32'h0, s}, 32, rrdes_pkg::P_TAB, 32));
   endfunction

   function automatic logic [63:0] cipher_block(input logic [63:0] blk);
      logic [63:0] b;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] nr;
      b = bit_select(blk, 64, rrdes_pkg::IP_TAB, 64);
      l = b[63:32];
      r = b[31:0];
      for (int i = 0; i < rrdes_pkg::NUM_ROUNDS; i++) begin
         nr = l ^ round_fn(r, key_sched[decrypting ? rrdes_pkg::NUM_ROUNDS - 1 - i : i]);
         l = r;
         r = nr;
      end
      return bit_select({r, l}, 64, rrdes_pkg::FP_TAB, 64);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   initial begin
      error_count    = 0;
      pending_blocks = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         load_key('0);
         decrypting = 1'b0;
         expected_blocks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0)
               report_mismatch($sformatf("unexpected block_out %h", rsp_tdata));
            else if (rsp_tdata !== expected_blocks[0])
               report_mismatch($sformatf("block_out %h, predicted %h",
                                         rsp_tdata, expected_blocks.pop_front()));
            else
               void'(expected_blocks.pop_front());
         end
         if (req_tvalid && req_tready)
            expected_blocks = {expected_blocks, cipher_block(req_tdata)};
         if (csr_valid && csr_ready) begin
            if (csr_index == rrdes_pkg::CSR_CIPHER_KEY) load_key(csr_data);
            else decrypting = csr_data[0];
         end
      end
      pending_blocks = expected_blocks.size();
   end
endmodule

[verif/testbench.sv]
// Top of the reduced-round DES testbench: stimulus, register phases, idling and verdict.
module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // block_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // block_out
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [63:0] csr_data;
   int          error_count;
   int          pending_blocks;
   int          stall_pct;
   int          idle_cycles;
   int          blocks_sent;
   int          phase_count;

   localparam int PIPE_LATENCY = rrdes_pkg::NUM_ROUNDS + 2;
   localparam int IDLE_LIMIT   = 2000;

   reduced_round_des_cipher_unit dut (.*);

   des_cipher_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls with the percentage that the current phase sets.
   initial rsp_tready = 1'b0;
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // The watchdog counts cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d blocks outstanding.", pending_blocks);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Writes one register; only called while the pipeline is empty.
   task automatic write_register(input logic idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one block, holding it until the unit takes it. The sender idles first
   // with the given percentage so gaps fall in every pipeline stage.
   task automatic send_block(input logic [63:0] blk, input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
   endtask

   // Lets every outstanding block come back, then waits out the pipeline depth.
   task automatic drain_pipeline;
      req_tvalid <= 1'b0;
      while (pending_blocks != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   function automatic logic [63:0] random_word;
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [63:0] key;
      int gap_pct;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = rrdes_pkg::CSR_CIPHER_KEY;
      csr_data   = '0;
      stall_pct  = 0;
      blocks_sent = 0;
      phase_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the reset key (all-zero subkeys), then extreme keys and
      // blocks in both directions, including a classic known-answer key.
      send_block('0, 0);
      send_block('1, 0);
      send_block(64'h0123456789ABCDEF, 0);
      drain_pipeline();
      for (int m = 0; m < 2; m++) begin
         for (int k = 0; k < 3; k++) begin
            key = (k == 0) ? 64'h0 : (k == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h1334_5779_9BBC_DFF1;
            write_register(rrdes_pkg::CSR_CIPHER_KEY, key);
            write_register(rrdes_pkg::CSR_DECRYPT_MODE,
                           m[0] ? 64'h1 : 64'hFFFF_FFFF_FFFF_FFFE);
            send_block('0, 0);
            send_block('1, 0);
            send_block(64'h8000_0000_0000_0001, 0);
            send_block(64'hAAAA_5555_AAAA_5555, 0);
            drain_pipeline();
            phase_count++;
         end
      end

      // Random part: twelve phases cycling through the idling patterns, each with a
      // fresh random key and mode, 1632 blocks in all.
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 54; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 54; end
            default: begin gap_pct = 36; stall_pct = 36; end
         endcase
         write_register(rrdes_pkg::CSR_CIPHER_KEY, random_word());
         write_register(rrdes_pkg::CSR_DECRYPT_MODE, {$urandom, $urandom});
         for (int n = 0; n < 136; n++) begin
            // Short bursts with no gap at all alternate with the phase's idling.
            send_block(random_word(), (n % 40 < 8) ? 0 : gap_pct);
         end
         drain_pipeline();
         phase_count++;
      end
      stall_pct = 0;

      $display("Ran %0d blocks through %0d key and mode settings,", blocks_sent, phase_count);
      $display("with sender gaps and receiver stalls in separate and combined phases.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[sim.f]
sv/rrdes_pkg.sv
sv/reduced_round_des_cipher_unit.sv
verif/des_cipher_checker.sv
verif/testbench.sv
